>>> rtl/grid_bilinear_light_sampler_macros.svh
// Assertion macros used by the light sampler port checker.
`ifndef GRID_BILINEAR_LIGHT_SAMPLER_MACROS_SVH
`define GRID_BILINEAR_LIGHT_SAMPLER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GBLS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gbls port check failed");

// Next-cycle implication, disabled while reset is high.
`define GBLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gbls port check failed");

`endif

>>> rtl/gbls_pkg.sv
// Shared types and constants of the bilinear light-grid sampler.
`default_nettype none
package gbls_pkg;

   typedef enum logic {
      REQ_WRITE  = 1'b0,
      REQ_SAMPLE = 1'b1
   } req_kind_type;

   localparam logic [15:0] INV_CELL_SCALE_RESET = 16'd655;

   // Widest linear grid address over the supported grid sizes (1024 x 1024).
   localparam int ADDR_W = 20;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic              is_sample;
      logic              in_range;
      logic [7:0]        frac_x;
      logic [7:0]        frac_y;
      logic [23:0]       light;
      logic [ADDR_W-1:0] addr;
   } entry_type;

endpackage
`default_nettype wire

>>> rtl/gbls_front.sv
// Front end: takes requests, scales positions and classifies them into queue entries.
`default_nettype none
module gbls_front #(
   parameter int GRID_SIZE = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_type,
   input  wire logic [15:0]         req_entry_index,
   input  wire logic [7:0]          req_entry_red,
   input  wire logic [7:0]          req_entry_green,
   input  wire logic [7:0]          req_entry_blue,
   input  wire logic signed [23:0]  req_pos_x,
   input  wire logic signed [23:0]  req_pos_y,
   input  wire logic                csr_valid,
   input  wire logic                csr_ready,
   input  wire logic [15:0]         csr_inv_cell_scale,
   input  wire logic                q_full,
   output logic                     push_valid,
   output gbls_pkg::entry_type      push_entry
);

   localparam int CW = $clog2(GRID_SIZE);
   localparam int AW = 2 * CW;
   localparam int unsigned CELL_COUNT = GRID_SIZE * GRID_SIZE;
   localparam logic [14:0] CELL_LIMIT = 15'(GRID_SIZE - 1);

   logic [15:0] scale_ff, scale_in;
   logic        en;

   // stage 1: request fields and scaled positions
   logic               f1_valid_ff;
   logic               f1_sample_ff;
   logic [15:0]        f1_idx_ff;
   logic [23:0]        f1_light_ff;
   logic [39:0]        f1_px_ff, f1_py_ff;
   logic signed [40:0] prod_x, prod_y;

   // stage 2: classified item
   logic          f2_valid_ff;
   logic          f2_keep_ff, f2_keep_in;
   logic          f2_sample_ff;
   logic          f2_in_range_ff, f2_in_range_in;
   logic [7:0]    f2_fx_ff, f2_fy_ff;
   logic [CW-1:0] f2_cx_ff, f2_cy_ff;
   logic [15:0]   f2_idx_ff;
   logic [23:0]   f2_light_ff;
   logic [AW-1:0] base;

   assign en        = ~f2_valid_ff | ~q_full;
   assign req_stall = ~en;

   assign scale_in = (csr_valid && csr_ready) ? csr_inv_cell_scale : scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= gbls_pkg::INV_CELL_SCALE_RESET;
      end else begin
         scale_ff <= scale_in;
      end
   end

   assign prod_x = req_pos_x * $signed({1'b0, scale_ff});
   assign prod_y = req_pos_y * $signed({1'b0, scale_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_sample_ff <= (req_type == gbls_pkg::REQ_SAMPLE);
         f1_idx_ff    <= req_entry_index;
         f1_light_ff  <= {req_entry_blue, req_entry_green, req_entry_red};
         f1_px_ff     <= prod_x[39:0];
         f1_py_ff     <= prod_y[39:0];
      end
   end

   // Negative scaled position or a cell index of GRID_SIZE-1 or more is out of range.
   always_comb begin
      f2_in_range_in = ~f1_px_ff[39] && ~f1_py_ff[39] &&
                       (f1_px_ff[38:24] < CELL_LIMIT) && (f1_py_ff[38:24] < CELL_LIMIT);
      f2_keep_in     = f1_sample_ff || (32'(f1_idx_ff) < CELL_COUNT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else if (en) begin
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f2_keep_ff     <= f2_keep_in;
         f2_sample_ff   <= f1_sample_ff;
         f2_in_range_ff <= f2_in_range_in;
         f2_fx_ff       <= f1_px_ff[23:16];
         f2_fy_ff       <= f1_py_ff[23:16];
         f2_cx_ff       <= f1_px_ff[24 +: CW];
         f2_cy_ff       <= f1_py_ff[24 +: CW];
         f2_idx_ff      <= f1_idx_ff;
         f2_light_ff    <= f1_light_ff;
      end
   end

   assign base = ({{CW{1'b0}}, f2_cy_ff} * AW'(GRID_SIZE)) + {{CW{1'b0}}, f2_cx_ff};

   always_comb begin
      push_valid           = f2_valid_ff & f2_keep_ff & ~q_full;
      push_entry.is_sample = f2_sample_ff;
      push_entry.in_range  = f2_in_range_ff;
      push_entry.frac_x    = f2_fx_ff;
      push_entry.frac_y    = f2_fy_ff;
      push_entry.light     = f2_light_ff;
      push_entry.addr      = f2_sample_ff ? gbls_pkg::ADDR_W'(base)
                                          : gbls_pkg::ADDR_W'(f2_idx_ff);
   end

endmodule
`default_nettype wire

>>> rtl/gbls_queue.sv
// Short queue of classified entries between the front and back ends.
`default_nettype none
module gbls_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  wire gbls_pkg::entry_type push_entry,
   output logic                     q_full,
   output logic                     q_valid,
   output gbls_pkg::entry_type      q_head,
   input  wire logic                pop
);

   localparam int PW = $clog2(gbls_pkg::QUEUE_DEPTH);

   gbls_pkg::entry_type slot_ff [gbls_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          do_pop;

   assign q_valid = (count_ff != '0);
   assign q_full  = (count_ff == (PW+1)'(gbls_pkg::QUEUE_DEPTH));
   assign q_head  = slot_ff[rd_ptr_ff];
   assign do_pop  = pop & q_valid;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push_valid) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

>>> rtl/gbls_back.sv
// Back end: light-grid store, corner fetch and the two blend stages.
`default_nettype none
module gbls_back #(
   parameter int GRID_SIZE = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire gbls_pkg::entry_type q_head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [7:0]               rsp_light_red,
   output logic [7:0]               rsp_light_green,
   output logic [7:0]               rsp_light_blue,
   output logic                     rsp_in_range
);

   localparam int CW  = $clog2(GRID_SIZE);
   localparam int AW  = 2 * CW;
   // only the first 65536 entries can ever be written
   localparam int MD  = (GRID_SIZE * GRID_SIZE > 65536) ? 65536 : GRID_SIZE * GRID_SIZE;
   localparam int MAW = $clog2(MD);

   // two copies of the grid: one serves the lower row, the other the upper row
   logic [23:0] mem_lo [MD];
   logic [23:0] mem_hi [MD];

   logic          en;
   logic          wr_en, rd_en;
   logic [AW-1:0] base;
   logic [AW-1:0] ra_a, ra_b, ra_c, ra_d;

   logic        b1_valid_ff;
   logic        b1_in_range_ff;
   logic [7:0]  b1_fx_ff, b1_fy_ff;
   logic [23:0] rd_a_ff, rd_b_ff, rd_c_ff, rd_d_ff;

   logic             b2_valid_ff;
   logic             b2_in_range_ff;
   logic [7:0]       b2_fx_ff;
   logic [2:0][15:0] left_ff, left_in;
   logic [2:0][15:0] right_ff, right_in;
   logic [8:0]       wy;

   logic             rsp_valid_ff;
   logic             rsp_in_range_ff;
   logic [2:0][7:0]  light_ff, light_in;
   logic [8:0]       wx;
   logic [23:0]      sum;

   assign en    = ~rsp_valid_ff | ~rsp_stall;
   assign pop   = q_valid & en;
   assign wr_en = pop & ~q_head.is_sample;
   assign rd_en = pop & q_head.is_sample;

   assign base = q_head.addr[AW-1:0];
   assign ra_a = base;
   assign ra_b = base + AW'(1);
   assign ra_d = base + AW'(GRID_SIZE);
   assign ra_c = base + AW'(GRID_SIZE + 1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_lo[q_head.addr[MAW-1:0]] <= q_head.light;
         mem_hi[q_head.addr[MAW-1:0]] <= q_head.light;
      end
      if (rd_en) begin
         rd_a_ff <= mem_lo[ra_a[MAW-1:0]];
         rd_b_ff <= mem_lo[ra_b[MAW-1:0]];
         rd_d_ff <= mem_hi[ra_d[MAW-1:0]];
         rd_c_ff <= mem_hi[ra_c[MAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         b1_valid_ff  <= rd_en;
         b2_valid_ff  <= b1_valid_ff;
         rsp_valid_ff <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         b1_in_range_ff <= q_head.in_range;
         b1_fx_ff       <= q_head.frac_x;
         b1_fy_ff       <= q_head.frac_y;
      end
   end

   // blend along y
   assign wy = 9'd256 - {1'b0, b1_fy_ff};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         left_in[k]  = {8'b0, rd_a_ff[8*k +: 8]} * {7'b0, wy}
                     + {8'b0, rd_d_ff[8*k +: 8]} * {8'b0, b1_fy_ff};
         right_in[k] = {8'b0, rd_b_ff[8*k +: 8]} * {7'b0, wy}
                     + {8'b0, rd_c_ff[8*k +: 8]} * {8'b0, b1_fy_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b2_in_range_ff <= b1_in_range_ff;
         b2_fx_ff       <= b1_fx_ff;
         left_ff        <= left_in;
         right_ff       <= right_in;
      end
   end

   // blend along x, round half up
   assign wx = 9'd256 - {1'b0, b2_fx_ff};

   always_comb begin
      sum = '0;
      for (int k = 0; k < 3; k++) begin
         sum         = {8'b0, left_ff[k]} * {15'b0, wx}
                     + {8'b0, right_ff[k]} * {16'b0, b2_fx_ff} + 24'h008000;
         light_in[k] = b2_in_range_ff ? sum[23:16] : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_in_range_ff <= b2_in_range_ff;
         light_ff        <= light_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_in_range    = rsp_in_range_ff;
   assign rsp_light_red   = light_ff[0];
   assign rsp_light_green = light_ff[1];
   assign rsp_light_blue  = light_ff[2];

endmodule
`default_nettype wire

>>> rtl/grid_bilinear_light_sampler.sv
// A sample passes the front end, queue and back end before rsp_valid. Throughput:
// one request (write or sample) per cycle while req_stall is low; each sample
// reads its four corners at once from two copies of the grid, two read ports each.
// Writes give no response; a 4-entry queue decouples the front and back pipelines.
// Reset (synchronous) clears control state and sets inv_cell_scale to 655;
// the grid contents are not cleared.
`default_nettype none
module grid_bilinear_light_sampler #(
   parameter int GRID_SIZE = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_type,
   input  wire logic [15:0]        req_entry_index,
   input  wire logic [7:0]         req_entry_red,
   input  wire logic [7:0]         req_entry_green,
   input  wire logic [7:0]         req_entry_blue,
   input  wire logic signed [23:0] req_pos_x,
   input  wire logic signed [23:0] req_pos_y,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_light_red,
   output logic [7:0]              rsp_light_green,
   output logic [7:0]              rsp_light_blue,
   output logic                    rsp_in_range,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [15:0]        csr_inv_cell_scale
);

   logic                q_full;
   logic                q_valid;
   logic                push_valid;
   logic                pop;
   gbls_pkg::entry_type push_entry;
   gbls_pkg::entry_type q_head;

   assign csr_ready = 1'b1;

   gbls_front #(
      .GRID_SIZE(GRID_SIZE)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_entry_index    (req_entry_index),
      .req_entry_red      (req_entry_red),
      .req_entry_green    (req_entry_green),
      .req_entry_blue     (req_entry_blue),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_inv_cell_scale (csr_inv_cell_scale),
      .q_full             (q_full),
      .push_valid         (push_valid),
      .push_entry         (push_entry)
   );

   gbls_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_full     (q_full),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .pop        (pop)
   );

   gbls_back #(
      .GRID_SIZE(GRID_SIZE)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_head          (q_head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_light_red   (rsp_light_red),
      .rsp_light_green (rsp_light_green),
      .rsp_light_blue  (rsp_light_blue),
      .rsp_in_range    (rsp_in_range)
   );

endmodule
`default_nettype wire

>>> rtl/gbls_port_checker.sv
// Port-level checks for the light sampler, bound to the top level.
`default_nettype none
`include "grid_bilinear_light_sampler_macros.svh"
module gbls_port_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [7:0]         rsp_light_red,
   input wire logic [7:0]         rsp_light_green,
   input wire logic [7:0]         rsp_light_blue,
   input wire logic               rsp_in_range
);

   // a stalled response holds until its transfer
   `GBLS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_light_red) && $stable(rsp_light_green) &&
      $stable(rsp_light_blue) && $stable(rsp_in_range))

   // out-of-range samples carry no light
   `GBLS_ASSERT_IMPL(a_out_of_range_dark, clock, reset, rsp_valid && !rsp_in_range,
      rsp_light_red == 8'd0 && rsp_light_green == 8'd0 && rsp_light_blue == 8'd0)

   // right after reset the pipeline is empty and takes requests
   `GBLS_ASSERT_IMPL(a_reset_empty, clock, reset, $fell(reset),
      !rsp_valid && !req_stall)

endmodule

bind grid_bilinear_light_sampler gbls_port_checker u_port_checker (.*);
`default_nettype wire
